FILE: rtl/core/ssu_pkg.sv
package ssu_pkg;

   // default sizes
   localparam int MAX_STATES_DEF  = 8;
   localparam int MAX_INPUTS_DEF  = 4;
   localparam int MAX_OUTPUTS_DEF = 4;

   // field and counter widths
   localparam int DATA_W = 24;
   localparam int NS_W   = 4;
   localparam int NI_W   = 3;
   localparam int NO_W   = 3;
   localparam int IDX_W  = 4;
   localparam int TERM_W = 5;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + 5;

   // function codes
   localparam logic [1:0] FUNC_COEF   = 2'd0;
   localparam logic [1:0] FUNC_STATE  = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   // matrix select codes
   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_C = 2'd2;
   localparam logic [1:0] SEL_D = 2'd3;

   // register indexes
   localparam logic [1:0] REG_NUM_STATES  = 2'd0;
   localparam logic [1:0] REG_NUM_INPUTS  = 2'd1;
   localparam logic [1:0] REG_NUM_OUTPUTS = 2'd2;

   typedef struct packed {
      logic [1:0]               func;
      logic [1:0]               matrix_sel;
      logic [2:0]               row;
      logic [2:0]               col;
      logic signed [DATA_W-1:0] load_value;
      logic signed [DATA_W-1:0] u_0;
      logic signed [DATA_W-1:0] u_1;
      logic signed [DATA_W-1:0] u_2;
      logic signed [DATA_W-1:0] u_3;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] y_value;
      logic [1:0]               y_index;
      logic                     last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic             issue;
      logic             out_phase;
      logic             in_term;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic rsp_busy;
   } sts_type;

endpackage

FILE: rtl/core/ssu_ram.sv
module ssu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/ssu_ctrl.sv
module ssu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [1:0]                req_func,
   input  logic [ssu_pkg::NS_W-1:0]  num_states,
   input  logic [ssu_pkg::NI_W-1:0]  num_inputs,
   input  logic [ssu_pkg::NO_W-1:0]  num_outputs,
   input  ssu_pkg::sts_type          sts,
   output logic                      req_ready,
   output ssu_pkg::cmd_type          cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_ISSUE  = 3'd2;
   localparam logic [2:0] S_WAIT   = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic                         out_phase_ff, out_phase_in;
   logic [ssu_pkg::IDX_W-1:0]    row_ff, row_in;
   logic [ssu_pkg::TERM_W-1:0]   term_ff, term_in;
   logic [ssu_pkg::TERM_W-1:0]   ns_ext, n_terms, col_full;
   logic                         in_term, last_term, last_row;

   // term decode: state columns first, then input columns
   assign ns_ext    = ssu_pkg::TERM_W'(num_states);
   assign n_terms   = ns_ext + ssu_pkg::TERM_W'(num_inputs);
   assign in_term   = (term_ff >= ns_ext);
   assign col_full  = in_term ? (term_ff - ns_ext) : term_ff;
   assign last_term = (term_ff == n_terms - ssu_pkg::TERM_W'(1));
   assign last_row  = out_phase_ff
                      ? (row_ff == ssu_pkg::IDX_W'(num_outputs) - ssu_pkg::IDX_W'(1))
                      : (row_ff == ssu_pkg::IDX_W'(num_states) - ssu_pkg::IDX_W'(1));

   assign req_ready     = (state_ff == S_IDLE);
   assign cmd.issue     = (state_ff == S_ISSUE);
   assign cmd.out_phase = out_phase_ff;
   assign cmd.in_term   = in_term;
   assign cmd.first     = (term_ff == '0);
   assign cmd.last      = last_term;
   assign cmd.row       = row_ff;
   assign cmd.col       = col_full[ssu_pkg::IDX_W-1:0];
   assign cmd.commit    = (state_ff == S_COMMIT);

   // sequencer over rows and terms
   always_comb begin
      state_in     = state_ff;
      out_phase_in = out_phase_ff;
      row_in       = row_ff;
      term_in      = term_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_func == ssu_pkg::FUNC_SAMPLE) begin
               state_in     = S_PREP;
               out_phase_in = 1'b1;
               row_in       = '0;
            end
         end
         S_PREP: begin
            term_in = '0;
            if (!(out_phase_ff && sts.rsp_busy)) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (last_term) begin
               state_in = S_WAIT;
            end else begin
               term_in = term_ff + ssu_pkg::TERM_W'(1);
            end
         end
         S_WAIT: begin
            if (!sts.pipe_busy) begin
               if (last_row && !out_phase_ff) begin
                  state_in = S_COMMIT;
               end else if (last_row) begin
                  out_phase_in = 1'b0;
                  row_in       = '0;
                  state_in     = S_PREP;
               end else begin
                  row_in   = row_ff + ssu_pkg::IDX_W'(1);
                  state_in = S_PREP;
               end
            end
         end
         S_COMMIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_phase_ff <= 1'b0;
         row_ff       <= '0;
         term_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_phase_ff <= out_phase_in;
         row_ff       <= row_in;
         term_ff      <= term_in;
      end
   end

endmodule

FILE: rtl/core/ssu_datapath.sv
module ssu_datapath #(
   parameter int MAX_STATES  = ssu_pkg::MAX_STATES_DEF,
   parameter int MAX_INPUTS  = ssu_pkg::MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = ssu_pkg::MAX_OUTPUTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  ssu_pkg::req_type          req_data,
   input  logic [ssu_pkg::NS_W-1:0]  num_states,
   input  logic [ssu_pkg::NI_W-1:0]  num_inputs,
   input  logic [ssu_pkg::NO_W-1:0]  num_outputs,
   input  ssu_pkg::cmd_type          cmd,
   output ssu_pkg::sts_type          sts,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ssu_pkg::rsp_type          rsp_data
);

   localparam int DW  = ssu_pkg::DATA_W;
   localparam int AW_ = ssu_pkg::ACC_W;
   localparam int SHW = AW_ - 16;
   localparam int DA  = MAX_STATES * MAX_STATES;
   localparam int DB  = MAX_STATES * MAX_INPUTS;
   localparam int DC  = MAX_OUTPUTS * MAX_STATES;
   localparam int DD  = MAX_OUTPUTS * MAX_INPUTS;
   localparam int AWA = (DA > 1) ? $clog2(DA) : 1;
   localparam int AWB = (DB > 1) ? $clog2(DB) : 1;
   localparam int AWC = (DC > 1) ? $clog2(DC) : 1;
   localparam int AWD = (DD > 1) ? $clog2(DD) : 1;
   localparam int SIW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int IIW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam logic signed [SHW-1:0] POS_MAX = SHW'(8388607);
   localparam logic signed [SHW-1:0] NEG_MIN = SHW'(-8388608);

   // state vector, next state and latched inputs
   logic signed [DW-1:0] x_ff  [MAX_STATES];
   logic signed [DW-1:0] nx_ff [MAX_STATES];
   logic signed [DW-1:0] u_ff  [MAX_INPUTS];
   logic signed [DW-1:0] u_in  [4];

   // entry valid bits, cleared by reset
   logic [DA-1:0] va_ff;
   logic [DB-1:0] vb_ff;
   logic [DC-1:0] vc_ff;
   logic [DD-1:0] vd_ff;
   logic          vra_ff, vrb_ff, vrc_ff, vrd_ff;

   logic [ssu_pkg::IDX_W-1:0] wrow, wcol;
   logic                      row_s, col_s, row_o, col_i;
   logic                      coef_wr, we_a, we_b, we_c, we_d;
   logic [AWA-1:0]            wa_a, ra_a;
   logic [AWB-1:0]            wa_b, ra_b;
   logic [AWC-1:0]            wa_c, ra_c;
   logic [AWD-1:0]            wa_d, ra_d;
   logic [DW-1:0]             q_a, q_b, q_c, q_d;

   // pipeline stages
   logic                      v1_ff, v2_ff, v3_ff;
   logic                      out1_ff, in1_ff, first1_ff, last1_ff;
   logic                      out2_ff, first2_ff, last2_ff;
   logic                      out3_ff;
   logic [ssu_pkg::IDX_W-1:0] row1_ff, row2_ff, row3_ff;
   logic signed [DW-1:0]      opnd1_ff, coef1;
   logic signed [ssu_pkg::PROD_W-1:0] prod_ff;
   logic signed [AW_-1:0]     acc_ff, acc_in, half_c, rnd;
   logic signed [SHW-1:0]     shifted;
   logic signed [DW-1:0]      sat;

   logic                      rsp_valid_ff;
   ssu_pkg::rsp_type          rsp_ff;

   // write address and bounds checks
   assign wrow  = ssu_pkg::IDX_W'(req_data.row);
   assign wcol  = ssu_pkg::IDX_W'(req_data.col);
   assign row_s = (wrow < ssu_pkg::IDX_W'(num_states));
   assign col_s = (wcol < ssu_pkg::IDX_W'(num_states));
   assign row_o = (wrow < ssu_pkg::IDX_W'(num_outputs));
   assign col_i = (wcol < ssu_pkg::IDX_W'(num_inputs));
   assign coef_wr = req_fire && req_data.func == ssu_pkg::FUNC_COEF;
   assign we_a = coef_wr && req_data.matrix_sel == ssu_pkg::SEL_A && row_s && col_s;
   assign we_b = coef_wr && req_data.matrix_sel == ssu_pkg::SEL_B && row_s && col_i;
   assign we_c = coef_wr && req_data.matrix_sel == ssu_pkg::SEL_C && row_o && col_s;
   assign we_d = coef_wr && req_data.matrix_sel == ssu_pkg::SEL_D && row_o && col_i;
   assign wa_a = AWA'(int'(wrow) * MAX_STATES + int'(wcol));
   assign wa_b = AWB'(int'(wrow) * MAX_INPUTS + int'(wcol));
   assign wa_c = AWC'(int'(wrow) * MAX_STATES + int'(wcol));
   assign wa_d = AWD'(int'(wrow) * MAX_INPUTS + int'(wcol));

   // read addresses from the sequencer
   assign ra_a = AWA'(int'(cmd.row) * MAX_STATES + int'(cmd.col));
   assign ra_b = AWB'(int'(cmd.row) * MAX_INPUTS + int'(cmd.col));
   assign ra_c = AWC'(int'(cmd.row) * MAX_STATES + int'(cmd.col));
   assign ra_d = AWD'(int'(cmd.row) * MAX_INPUTS + int'(cmd.col));

   ssu_ram #(.WIDTH(DW), .DEPTH(DA)) u_ram_a (
      .clock(clock), .wr_en(we_a), .wr_addr(wa_a), .wr_data(req_data.load_value),
      .rd_addr(ra_a), .rd_data(q_a));
   ssu_ram #(.WIDTH(DW), .DEPTH(DB)) u_ram_b (
      .clock(clock), .wr_en(we_b), .wr_addr(wa_b), .wr_data(req_data.load_value),
      .rd_addr(ra_b), .rd_data(q_b));
   ssu_ram #(.WIDTH(DW), .DEPTH(DC)) u_ram_c (
      .clock(clock), .wr_en(we_c), .wr_addr(wa_c), .wr_data(req_data.load_value),
      .rd_addr(ra_c), .rd_data(q_c));
   ssu_ram #(.WIDTH(DW), .DEPTH(DD)) u_ram_d (
      .clock(clock), .wr_en(we_d), .wr_addr(wa_d), .wr_data(req_data.load_value),
      .rd_addr(ra_d), .rd_data(q_d));

   // valid bits and their registered read
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
         vc_ff <= '0;
         vd_ff <= '0;
      end else begin
         if (we_a) va_ff[wa_a] <= 1'b1;
         if (we_b) vb_ff[wa_b] <= 1'b1;
         if (we_c) vc_ff[wa_c] <= 1'b1;
         if (we_d) vd_ff[wa_d] <= 1'b1;
      end
      vra_ff <= va_ff[ra_a];
      vrb_ff <= vb_ff[ra_b];
      vrc_ff <= vc_ff[ra_c];
      vrd_ff <= vd_ff[ra_d];
   end

   // input vector as an array
   assign u_in[0] = req_data.u_0;
   assign u_in[1] = req_data.u_1;
   assign u_in[2] = req_data.u_2;
   assign u_in[3] = req_data.u_3;

   always_ff @(posedge clock) begin
      if (req_fire && req_data.func == ssu_pkg::FUNC_SAMPLE) begin
         for (int k = 0; k < MAX_INPUTS; k++) begin
            u_ff[k] <= u_in[k];
         end
      end
   end

   // state vector: preset, commit of next state, reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_STATES; k++) begin
            x_ff[k] <= '0;
         end
      end else if (req_fire && req_data.func == ssu_pkg::FUNC_STATE && row_s) begin
         x_ff[wrow[SIW-1:0]] <= req_data.load_value;
      end else if (cmd.commit) begin
         for (int k = 0; k < MAX_STATES; k++) begin
            if (k < int'(num_states)) begin
               x_ff[k] <= nx_ff[k];
            end
         end
      end
   end

   // stage 1: operand fetch alongside the coefficient read
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
      end
      out1_ff   <= cmd.out_phase;
      in1_ff    <= cmd.in_term;
      first1_ff <= cmd.first;
      last1_ff  <= cmd.last;
      row1_ff   <= cmd.row;
      opnd1_ff  <= cmd.in_term ? u_ff[cmd.col[IIW-1:0]] : x_ff[cmd.col[SIW-1:0]];
   end

   // coefficient choice, unwritten entries read as zero
   always_comb begin
      case ({out1_ff, in1_ff})
         2'b00:   coef1 = vra_ff ? q_a : '0;
         2'b01:   coef1 = vrb_ff ? q_b : '0;
         2'b10:   coef1 = vrc_ff ? q_c : '0;
         default: coef1 = vrd_ff ? q_d : '0;
      endcase
   end

   // stage 2: product
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      prod_ff   <= coef1 * opnd1_ff;
      out2_ff   <= out1_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      row2_ff   <= row1_ff;
   end

   // stage 3: accumulate
   assign acc_in = first2_ff ? AW_'(prod_ff) : acc_ff + AW_'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff && last2_ff;
      end
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      out3_ff <= out2_ff;
      row3_ff <= row2_ff;
   end

   // stage 4: round half up and saturate
   assign half_c  = AW_'(32768);
   assign rnd     = acc_ff + half_c;
   assign shifted = SHW'(rnd >>> 16);
   assign sat     = (shifted > POS_MAX) ? DW'(8388607)
                  : (shifted < NEG_MIN) ? DW'(-8388608) : DW'(shifted);

   always_ff @(posedge clock) begin
      if (v3_ff && !out3_ff) begin
         nx_ff[row3_ff[SIW-1:0]] <= sat;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (v3_ff && out3_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (v3_ff && out3_ff) begin
         rsp_ff.y_value <= sat;
         rsp_ff.y_index <= row3_ff[1:0];
         rsp_ff.last    <= (row3_ff == ssu_pkg::IDX_W'(num_outputs) - ssu_pkg::IDX_W'(1));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign sts.pipe_busy = v1_ff || v2_ff || v3_ff;
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule

FILE: rtl/core/state_space_system_step_unit.sv
// coefficient and state requests: taken back to back
// sample request: runs every output row and then every state row through one
// shared multiply-accumulate doing one product per cycle while it issues terms,
// and stalls while an output result waits for rsp_ready; one sample at a time
// reset: state vector and coefficient stores read as zero, dimension registers 1
module state_space_system_step_unit #(
   parameter int MAX_STATES  = ssu_pkg::MAX_STATES_DEF,
   parameter int MAX_INPUTS  = ssu_pkg::MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = ssu_pkg::MAX_OUTPUTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssu_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [ssu_pkg::NS_W-1:0] num_states_ff, num_states_in;
   logic [ssu_pkg::NI_W-1:0] num_inputs_ff, num_inputs_in;
   logic [ssu_pkg::NO_W-1:0] num_outputs_ff, num_outputs_in;
   logic                     csr_wr, req_fire;
   logic [3:0]               wv_s;
   logic [2:0]               wv_i, wv_o;
   ssu_pkg::cmd_type         cmd;
   ssu_pkg::sts_type         sts;

   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite;
   assign req_fire = req_valid && req_ready;
   assign wv_s     = pwdata[3:0];
   assign wv_i     = pwdata[2:0];
   assign wv_o     = pwdata[2:0];

   // dimension registers, clamped into range
   always_comb begin
      num_states_in  = num_states_ff;
      num_inputs_in  = num_inputs_ff;
      num_outputs_in = num_outputs_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            ssu_pkg::REG_NUM_STATES: begin
               num_states_in = (wv_s == '0) ? ssu_pkg::NS_W'(1)
                             : (int'(wv_s) > MAX_STATES) ? ssu_pkg::NS_W'(MAX_STATES)
                             : wv_s;
            end
            ssu_pkg::REG_NUM_INPUTS: begin
               num_inputs_in = (wv_i == '0) ? ssu_pkg::NI_W'(1)
                             : (int'(wv_i) > MAX_INPUTS) ? ssu_pkg::NI_W'(MAX_INPUTS)
                             : wv_i;
            end
            ssu_pkg::REG_NUM_OUTPUTS: begin
               num_outputs_in = (wv_o == '0) ? ssu_pkg::NO_W'(1)
                              : (int'(wv_o) > MAX_OUTPUTS) ? ssu_pkg::NO_W'(MAX_OUTPUTS)
                              : wv_o;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff  <= ssu_pkg::NS_W'(1);
         num_inputs_ff  <= ssu_pkg::NI_W'(1);
         num_outputs_ff <= ssu_pkg::NO_W'(1);
      end else begin
         num_states_ff  <= num_states_in;
         num_inputs_ff  <= num_inputs_in;
         num_outputs_ff <= num_outputs_in;
      end
   end

   // register read back
   always_comb begin
      case (paddr[3:2])
         ssu_pkg::REG_NUM_STATES:  prdata = 32'(num_states_ff);
         ssu_pkg::REG_NUM_INPUTS:  prdata = 32'(num_inputs_ff);
         ssu_pkg::REG_NUM_OUTPUTS: prdata = 32'(num_outputs_ff);
         default:                  prdata = '0;
      endcase
   end

   ssu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_func    (req_data.func),
      .num_states  (num_states_ff),
      .num_inputs  (num_inputs_ff),
      .num_outputs (num_outputs_ff),
      .sts         (sts),
      .req_ready   (req_ready),
      .cmd         (cmd)
   );

   ssu_datapath #(
      .MAX_STATES  (MAX_STATES),
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_data    (req_data),
      .num_states  (num_states_ff),
      .num_inputs  (num_inputs_ff),
      .num_outputs (num_outputs_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
